>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clk edge outside reset.
`define BCHL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that expr never holds outside reset.
`define BCHL_ASSERT_NEVER(label, expr, msg) \
	`BCHL_ASSERT(label, !(expr), msg)

`endif

>>> rtl/core/bchl_pkg.sv
// Types, constants and the lowest-button search for the button lock block.
`timescale 1ns / 1ps
package bchl_pkg;

	localparam int MASK_W       = 16;
	localparam int POS_W        = 4;
	localparam int TIME_W       = 32;
	localparam int BUTTON_COUNT = 16;

	localparam logic [MASK_W-1:0] PREV_RESET      = 16'hFFFF;
	localparam logic [MASK_W-1:0] LOCK_HOLD_RESET = 16'd1500;
	localparam logic [POS_W-1:0]  START_RESET     = 4'd14;
	localparam logic [POS_W-1:0]  STOP_RESET      = 4'd15;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LOCK_HOLD = 2'd0;
	localparam logic [1:0] CFG_START     = 2'd1;
	localparam logic [1:0] CFG_STOP      = 2'd2;

	typedef struct packed {
		logic [MASK_W-1:0] lock_hold_ms;
		logic [POS_W-1:0]  start_index;
		logic [POS_W-1:0]  stop_index;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              wait_check;
		logic [MASK_W-1:0] second_reading;
		logic [MASK_W-1:0] first_reading;
	} item_t;

	typedef struct packed {
		logic              changed;
		logic [MASK_W-1:0] locked_mask;
		logic [MASK_W-1:0] pressed_mask;
		logic [MASK_W-1:0] reported_mask;
	} result_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} btn_hit_t;

	// Priority-encode the lowest set bit inside the button range.
	function automatic btn_hit_t lowest_button(logic [MASK_W-1:0] mask);
		btn_hit_t r;
		r.found = 1'b0;
		r.pos   = '0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (mask[i]) begin
				r.found = 1'b1;
				r.pos   = i[POS_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/button_change_and_hold_lock_top.sv
// Top level of the button change detector with hold-to-lock.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | poll: two readings, wait flag, time
//  m_*     | out       | m_tvalid/m_tready  | result: changed, report/press/lock
//  cfg_*   | in        | cfg_we             | register index and write data
//
// One item per cycle unless m_tready stalls: a poll sits in the input register
// while the decision logic reads the button state, then moves to the result
// register. m_tvalid rises as the poll lands in the result register.
// The state registers advance only when the poll moves into the result register,
// so a stall on m_tready holds both the poll and the state.
// Reset (arst_n low) sets all buttons down in the state, no lock, timer at zero.
`timescale 1ns / 1ps
module button_change_and_hold_lock_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] first_reading, [31:16] second_reading, [63:32] now_ms
	input  logic [63:0] s_tdata,
	// [0] wait_check
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] reported_mask, [31:16] pressed_mask, [47:32] locked_mask
	output logic [47:0] m_tdata,
	// [0] changed
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import bchl_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res, result_q;
	logic    m_tvalid_q;
	logic    advance;

	// Move the poll on whenever the result register is free or being drained.
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_hold_ms <= LOCK_HOLD_RESET;
			cfg_q.start_index  <= START_RESET;
			cfg_q.stop_index   <= STOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCK_HOLD: cfg_q.lock_hold_ms <= cfg_wdata;
				CFG_START:     cfg_q.start_index  <= cfg_wdata[POS_W-1:0];
				CFG_STOP:      cfg_q.stop_index   <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: hold the poll until the result side can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.first_reading  <= s_tdata[15:0];
			item_s1.second_reading <= s_tdata[31:16];
			item_s1.now_ms         <= s_tdata[63:32];
			item_s1.wait_check     <= s_tuser;
		end
	end

	bchl_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register: load when advancing, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (advance)
			m_tvalid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = result_q.changed;
	assign m_tdata  = {result_q.locked_mask, result_q.pressed_mask, result_q.reported_mask};

endmodule

>>> rtl/core/bchl_engine.sv
// Button state, lock and hold timer with the per-poll decision logic.
`timescale 1ns / 1ps
module bchl_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bchl_pkg::item_t  item,
	input  bchl_pkg::cfg_t   cfg,
	output bchl_pkg::result_t res
);
	import bchl_pkg::*;

	logic [MASK_W-1:0] prev_q, lock_q, prev_n, lock_n, pressed;
	logic [TIME_W-1:0] hold_q, hold_n, elapsed;
	logic              ignore, chg;
	btn_hit_t          p_hit, o_hit, l_hit;

	// Clear is allowed unless the trigger is start while the lock is stop.
	function automatic logic clear_ok(btn_hit_t held, logic [POS_W-1:0] btn,
			cfg_t c);
		return held.found && (btn != c.start_index || held.pos != c.stop_index);
	endfunction

	always_comb begin
		ignore  = item.wait_check && (item.first_reading != item.second_reading);
		chg     = !ignore && (item.first_reading != prev_q);
		pressed = chg ? (item.first_reading & ~prev_q) : '0;
		p_hit   = lowest_button(pressed);
		o_hit   = lowest_button(prev_q);
		l_hit   = lowest_button(lock_q);
		elapsed = item.now_ms - hold_q;

		prev_n = prev_q;
		lock_n = lock_q;
		hold_n = hold_q;
		res.reported_mask = '0;

		if (chg) begin
			prev_n = item.first_reading;
			res.reported_mask = item.first_reading;
			if (p_hit.found) begin
				res.reported_mask = item.first_reading | lock_q;
				if (clear_ok(l_hit, p_hit.pos, cfg))
					lock_n = '0;
				hold_n = item.now_ms;
			end else if (o_hit.found && lock_q != prev_q) begin
				if (clear_ok(l_hit, o_hit.pos, cfg))
					lock_n = '0;
			end
		end else if (!ignore && prev_q != '0 && lock_q == '0) begin
			if (elapsed > {{(TIME_W-MASK_W){1'b0}}, cfg.lock_hold_ms})
				lock_n = prev_q;
		end

		res.changed      = chg;
		res.pressed_mask = pressed;
		res.locked_mask  = lock_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= PREV_RESET;
			lock_q <= '0;
			hold_q <= '0;
		end else if (en) begin
			prev_q <= prev_n;
			lock_q <= lock_n;
			hold_q <= hold_n;
		end
	end

endmodule

>>> rtl/core/bchl_checker.sv
// Port-level checks for the button lock block and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bchl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	`BCHL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped under stall")
	`BCHL_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result moved under stall")
	`BCHL_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")
	`BCHL_ASSERT_NEVER(a_quiet_unchanged, m_tvalid && !m_tuser && (m_tdata[31:0] != 32'd0),
		"report or press on unchanged poll")
	`BCHL_ASSERT_NEVER(a_press_in_report, m_tvalid && ((m_tdata[31:16] & ~m_tdata[15:0]) != 16'd0),
		"pressed bit missing from report")

endmodule

bind button_change_and_hold_lock_top bchl_checker u_bchl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> verif/button_change_and_hold_lock_top_tb.sv
// Self-checking testbench for the button change detector with hold-to-lock.
`timescale 1ns / 1ps

import bchl_pkg::*;

class lock_scoreboard;
	logic [MASK_W-1:0] hold_ms;
	logic [POS_W-1:0]  start_pos;
	logic [POS_W-1:0]  stop_pos;
	logic [MASK_W-1:0] state_mask;
	logic [MASK_W-1:0] lock_mask;
	logic [TIME_W-1:0] press_ms;
	result_t           expected_results[$];
	int                errors;
	int                polls;
	int                ignored;
	int                checked;
	int                changes;
	int                locked_results;

	function new();
		hold_ms        = 16'd1500;
		start_pos      = 4'd14;
		stop_pos       = 4'd15;
		state_mask     = 16'hFFFF;
		lock_mask      = '0;
		press_ms       = '0;
		errors         = 0;
		polls          = 0;
		ignored        = 0;
		checked        = 0;
		changes        = 0;
		locked_results = 0;
	endfunction

	function void set_register(input logic [1:0] idx, input logic [15:0] value);
		case (idx)
			CFG_LOCK_HOLD: hold_ms   = value;
			CFG_START:     start_pos = value[POS_W-1:0];
			CFG_STOP:      stop_pos  = value[POS_W-1:0];
			default: ;
		endcase
	endfunction

	// Position of the lowest button held down; returns 0 when none is down.
	function bit lowest_down(input logic [MASK_W-1:0] m, output logic [POS_W-1:0] pos);
		pos = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (m[i]) begin
				pos = POS_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Drop the lock unless start was pressed while stop holds the lock.
	function void drop_lock(input logic [POS_W-1:0] btn);
		logic [POS_W-1:0] held_pos;
		if (lowest_down(lock_mask, held_pos) && (btn != start_pos || held_pos != stop_pos))
			lock_mask = '0;
	endfunction

	function void note_poll(input item_t p);
		result_t           r;
		logic [MASK_W-1:0] old;
		logic [POS_W-1:0]  btn;
		logic [TIME_W-1:0] elapsed;
		r = '0;
		polls++;
		if (p.wait_check && p.first_reading != p.second_reading) begin
			ignored++;
		end else if (p.first_reading != state_mask) begin
			old             = state_mask;
			r.changed       = 1'b1;
			r.pressed_mask  = p.first_reading & ~old;
			r.reported_mask = p.first_reading;
			state_mask      = p.first_reading;
			if (lowest_down(r.pressed_mask, btn)) begin
				r.reported_mask |= lock_mask;
				drop_lock(btn);
				press_ms = p.now_ms;
			end else if (lowest_down(old, btn)) begin
				if (lock_mask != old)
					drop_lock(btn);
			end
		end else if (state_mask != '0 && lock_mask == '0) begin
			elapsed = p.now_ms - press_ms;
			if (elapsed > {16'd0, hold_ms})
				lock_mask = state_mask;
		end
		r.locked_mask = lock_mask;
		expected_results.push_back(r);
	endfunction

	function void check_result(input result_t got);
		result_t exp_r;
		if (expected_results.size() == 0) begin
			$error("result with no poll waiting: %h", got);
			errors++;
			return;
		end
		exp_r = expected_results.pop_front();
		checked++;
		if (got.changed) changes++;
		if (got.locked_mask != '0) locked_results++;
		if (got.changed !== exp_r.changed) begin
			$error("changed: expected %h actual %h", exp_r.changed, got.changed);
			errors++;
		end
		if (got.reported_mask !== exp_r.reported_mask) begin
			$error("reported_mask: expected %h actual %h", exp_r.reported_mask,
				got.reported_mask);
			errors++;
		end
		if (got.pressed_mask !== exp_r.pressed_mask) begin
			$error("pressed_mask: expected %h actual %h", exp_r.pressed_mask,
				got.pressed_mask);
			errors++;
		end
		if (got.locked_mask !== exp_r.locked_mask) begin
			$error("locked_mask: expected %h actual %h", exp_r.locked_mask,
				got.locked_mask);
			errors++;
		end
	endfunction
endclass

module button_change_and_hold_lock_top_tb;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_LOCK_HOLD;
	logic [15:0] cfg_wdata = '0;

	lock_scoreboard sb;

	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	logic [MASK_W-1:0] held_buttons  = '0;
	logic [TIME_W-1:0] clock_ms      = '0;
	logic [MASK_W-1:0] cur_hold      = 16'd1500;
	logic [POS_W-1:0]  cur_start     = 4'd14;
	logic [POS_W-1:0]  cur_stop      = 4'd15;

	item_t   bus_poll;
	result_t bus_result;

	// Unpack both buses into the package structs.
	assign bus_poll   = {s_tdata[63:32], s_tuser, s_tdata[31:16], s_tdata[15:0]};
	assign bus_result = {m_tuser, m_tdata[47:32], m_tdata[31:16], m_tdata[15:0]};

	button_change_and_hold_lock_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs on either handshake.
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Sample both handshakes at the rising edge: predict on input, compare on output.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_poll(bus_poll);
			if (m_tvalid && m_tready)
				sb.check_result(bus_result);
		end
	end

	// Backpressure: drop tready for the current share of cycles.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one item, with random gaps before it; return at the falling edge after accept.
	task automatic send_poll(input item_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.now_ms, p.second_reading, p.first_reading};
		s_tuser  <= p.wait_check;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic poll_once(input logic [15:0] first, input logic [15:0] second,
		input logic wait_flag, input logic [31:0] t);
		item_t p;
		p.first_reading  = first;
		p.second_reading = second;
		p.wait_check     = wait_flag;
		p.now_ms         = t;
		send_poll(p);
	endtask

	// Hold off new items until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write all three registers back to back; only called with the block idle.
	task automatic write_config(input logic [15:0] hold, input logic [3:0] start_b,
		input logic [3:0] stop_b);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOCK_HOLD;
		cfg_wdata <= hold;
		@(negedge clk);
		cfg_index <= CFG_START;
		cfg_wdata <= {12'd0, start_b};
		@(negedge clk);
		cfg_index <= CFG_STOP;
		cfg_wdata <= {12'd0, stop_b};
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(CFG_LOCK_HOLD, hold);
		sb.set_register(CFG_START, {12'd0, start_b});
		sb.set_register(CFG_STOP, {12'd0, stop_b});
		cur_hold  = hold;
		cur_start = start_b;
		cur_stop  = stop_b;
	endtask

	// Button sessions: pick a target state, hold it for a few polls while time runs,
	// with some ignored polls, disagreeing reads and random noise mixed in.
	task automatic run_segment(input int n_polls);
		int                sent;
		int                hold_len;
		int                roll;
		logic [MASK_W-1:0] bits;
		item_t             p;
		sent = 0;
		while (sent < n_polls) begin
			case ($urandom_range(9))
				0, 1:    bits = 16'd1 << $urandom_range(15);
				2:       bits = 16'd1 << cur_start;
				3:       bits = 16'd1 << cur_stop;
				4:       bits = (16'd1 << cur_start) | (16'd1 << cur_stop);
				5:       bits = '0;
				6:       bits = 16'($urandom());
				7:       bits = 16'($urandom()) & 16'($urandom());
				8:       bits = 16'hFFFF;
				default: bits = (16'd1 << cur_stop) | (16'($urandom()) & 16'($urandom()));
			endcase
			case ($urandom_range(2))
				0:       held_buttons = bits;
				1:       held_buttons = held_buttons | bits;
				default: held_buttons = held_buttons & ~bits;
			endcase
			hold_len = $urandom_range(1, 8);
			repeat (hold_len) begin
				// Advance time in steps scaled to the hold threshold; jump now and then.
				if ($urandom_range(99) < 3)
					clock_ms = $urandom();
				else if ($urandom_range(3) == 0)
					clock_ms = clock_ms + $urandom_range(3);
				else
					clock_ms = clock_ms + $urandom_range(int'(cur_hold) / 3 + 2);
				p.now_ms = clock_ms;
				roll     = $urandom_range(99);
				if (roll < 12) begin
					// Disagreeing reads with the check on: ignored by the block.
					p.first_reading  = held_buttons;
					p.second_reading = held_buttons ^ 16'($urandom_range(1, 65535));
					p.wait_check     = 1'b1;
				end else if (roll < 20) begin
					// Disagreeing reads with the check off: first read wins.
					p.first_reading  = held_buttons;
					p.second_reading = 16'($urandom());
					p.wait_check     = 1'b0;
				end else if (roll < 26) begin
					p.first_reading  = 16'($urandom());
					p.second_reading = $urandom_range(1) ? p.first_reading : 16'($urandom());
					p.wait_check     = 1'($urandom_range(1));
				end else begin
					p.first_reading  = held_buttons;
					p.second_reading = held_buttons;
					p.wait_check     = 1'($urandom_range(1));
				end
				send_poll(p);
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 36;
		recv_idle_pct = 77;

		// Hold reset, then release it on a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed run at reset settings (hold 1500, start 14, stop 15).
		// All-down reset state locks once held past the threshold, not at it.
		poll_once(16'hFFFF, 16'hFFFF, 1'b1, 32'd0);
		poll_once(16'hFFFF, 16'hFFFF, 1'b1, 32'd1500);
		poll_once(16'hFFFF, 16'hFFFF, 1'b0, 32'd1501);
		// Ignored poll, then a disagreeing pair accepted with the check off.
		poll_once(16'hFFFF, 16'h0000, 1'b1, 32'd1502);
		poll_once(16'h0000, 16'hFFFF, 1'b0, 32'd1503);
		// New press of button 0 clears the lock.
		poll_once(16'h0001, 16'h0001, 1'b1, 32'd1504);
		poll_once(16'h0001, 16'h0001, 1'b1, 32'd3005);
		// Release matching the lock keeps it; a start press clears a non-stop lock.
		poll_once(16'h0000, 16'h0000, 1'b1, 32'd3006);
		poll_once(16'h4000, 16'h4000, 1'b1, 32'd3007);
		poll_once(16'h0000, 16'h0000, 1'b0, 32'd3008);
		// Stop locks, then start pressed and released keeps the stop lock.
		poll_once(16'h8000, 16'h8000, 1'b1, 32'd3009);
		poll_once(16'h8000, 16'h8000, 1'b1, 32'd4510);
		poll_once(16'hC000, 16'hC000, 1'b1, 32'd4511);
		poll_once(16'h4000, 16'h4000, 1'b1, 32'd4512);
		poll_once(16'h0000, 16'h0000, 1'b1, 32'd4513);
		poll_once(16'h0001, 16'h0001, 1'b1, 32'd4514);
		// Partial release keeps a matching lock; the next release clears it.
		poll_once(16'h0003, 16'h0003, 1'b1, 32'd4515);
		poll_once(16'h0003, 16'h0003, 1'b1, 32'd6016);
		poll_once(16'h0001, 16'h0001, 1'b1, 32'd6017);
		poll_once(16'h0000, 16'h0000, 1'b1, 32'd6018);
		// All up: no lock check at all.
		poll_once(16'h0000, 16'h0000, 1'b1, 32'd6019);
		// Elapsed time wraps through zero.
		poll_once(16'hAAAA, 16'hAAAA, 1'b1, 32'hFFFF_FF00);
		poll_once(16'hAAAA, 16'hAAAA, 1'b0, 32'h0000_05DD);
		poll_once(16'h5555, 16'h5555, 1'b1, 32'h0000_1000);
		poll_once(16'h5555, 16'h5554, 1'b1, 32'hFFFF_FFFF);

		held_buttons = 16'h5555;
		clock_ms     = 32'hFFFF_F000;

		// Six random segments, each with its own register setting; idle pattern
		// changes every two segments.
		for (int seg = 0; seg < 6; seg++) begin
			drain_results();
			case (seg / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: write_config(16'd0, 4'd0, 4'd15);
				1: write_config(16'hFFFF, 4'd15, 4'd0);
				2: write_config(16'($urandom_range(1, 300)), 4'($urandom()), 4'($urandom()));
				3: write_config(16'd1500, 4'd14, 4'd15);
				4: write_config(16'd37, 4'd3, 4'd3);
				default: write_config(16'($urandom()), 4'd15, 4'd15);
			endcase
			run_segment(280);
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d polls (%0d ignored) over seven register settings and three idle",
			sb.polls, sb.ignored);
		$display("patterns; %0d results checked, %0d with a change, %0d with a lock held",
			sb.checked, sb.changes, sb.locked_results);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bchl_pkg.sv
rtl/core/bchl_engine.sv
rtl/core/button_change_and_hold_lock_top.sv
rtl/core/bchl_checker.sv
verif/button_change_and_hold_lock_top_tb.sv
